>>> design/divider_scaled_moving_average_top_macros.svh
// Assertion macros for the scaled moving-average monitor.
`ifndef DIVIDER_SCALED_MOVING_AVERAGE_TOP_MACROS_SVH
`define DIVIDER_SCALED_MOVING_AVERAGE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define DSMA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dsma assertion failed");

`define DSMA_ASSERT(lbl, prop) \
  `DSMA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define DSMA_ASSERT_CLK(lbl, clk, rstn, prop)

`define DSMA_ASSERT(lbl, prop)

`endif

`endif

>>> design/dsma_pkg.sv
// Types and constants shared by the scaled moving-average monitor.
package dsma_pkg;

  localparam int SMP_W  = 16;
  localparam int RES_W  = 20;
  localparam int RAT_W  = RES_W + 1;
  localparam int DVD_W  = SMP_W + RAT_W;
  localparam int DVS_W  = RES_W;
  localparam int CNT_W  = 6;
  localparam int SUM_W  = 24;
  localparam int HELD_W = 8;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  localparam logic [SMP_W-1:0] SAT16 = 16'hFFFF;

  localparam logic [SMP_W-1:0] FS_RESET     = 16'd3600;
  localparam logic [RES_W-1:0] TOP_RESET    = 20'd100000;
  localparam logic [RES_W-1:0] BOTTOM_RESET = 20'd100000;

  localparam logic [IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_FS     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_TOP    = 2'd2;
  localparam logic [IDX_W-1:0] CFG_BOTTOM = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_MV,
    ST_LD_MV,
    ST_WAIT_MV,
    ST_MUL_SC,
    ST_LD_SC,
    ST_WAIT_SC,
    ST_UPDATE,
    ST_LD_AVG,
    ST_WAIT_AVG,
    ST_RESP
  } dsma_state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/dsma_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module dsma_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dsma_pkg::div_req_t req_i,
  output dsma_pkg::div_rsp_t rsp_o
);

  logic [dsma_pkg::DVD_W-1:0] q_q;
  logic [dsma_pkg::DVS_W-1:0] r_q;
  logic [dsma_pkg::DVS_W-1:0] d_q;
  logic [dsma_pkg::CNT_W-1:0] cnt_q;
  logic                       busy_q;
  logic                       done_q;
  logic [dsma_pkg::DVS_W:0]   rs;
  logic [dsma_pkg::DVS_W:0]   diff;

  assign rs   = {r_q, q_q[dsma_pkg::DVD_W-1]};
  assign diff = rs - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q    <= '0;
      r_q    <= '0;
      d_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      q_q    <= req_i.dividend;
      r_q    <= '0;
      d_q    <= req_i.divisor;
      cnt_q  <= req_i.steps;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      q_q   <= {q_q[dsma_pkg::DVD_W-2:0], ~diff[dsma_pkg::DVS_W]};
      r_q   <= diff[dsma_pkg::DVS_W] ? rs[dsma_pkg::DVS_W-1:0] : diff[dsma_pkg::DVS_W-1:0];
      cnt_q <= cnt_q - dsma_pkg::CNT_W'(1);
      if (cnt_q == dsma_pkg::CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = q_q;

endmodule

>>> design/dsma_window.sv
// Sample ring with running sum and fill count.
module dsma_window #(
  parameter int DEPTH  = 8,
  parameter int SLOT_W = 3,
  parameter int FILL_W = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [dsma_pkg::SMP_W-1:0] sample_i,
  output logic [dsma_pkg::SUM_W-1:0] sum_o,
  output logic [FILL_W-1:0]          fill_o
);

  logic [dsma_pkg::SMP_W-1:0] mem [DEPTH];
  logic [dsma_pkg::SMP_W-1:0] old_q;
  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic [FILL_W-1:0]          fill_q, fill_d;
  logic [dsma_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                       full;

  always_ff @(posedge clk_i) begin
    old_q <= mem[slot_q];
    if (push_i) begin
      mem[slot_q] <= sample_i;
    end
  end

  assign full = (fill_q == FILL_W'(DEPTH));

  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    if (push_i) begin
      slot_d = (slot_q == SLOT_W'(DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
      fill_d = full ? fill_q : fill_q + FILL_W'(1);
      sum_d  = sum_q + dsma_pkg::SUM_W'(sample_i)
             - (full ? dsma_pkg::SUM_W'(old_q) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

>>> design/divider_scaled_moving_average_top.sv
// Top level of the scaled moving-average voltage monitor.
// A good sample gets its result from the shared restoring divider, which produces one quotient
// bit per cycle over three divisions: code to millivolts (CODE_BITS + 16 steps), divider ratio
// (37 steps, skipped for a zero bottom resistor) and window average (24 steps). A failed
// conversion or a disabled monitor goes straight to the result state with no division.
// A new request is taken only once the previous result has moved into the output register, so
// a stalled output holds the block.
`include "divider_scaled_moving_average_top_macros.svh"

module divider_scaled_moving_average_top #(
  parameter int WINDOW_DEPTH = 8,
  parameter int CODE_BITS    = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dsma_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [dsma_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [CODE_BITS-1:0]        adc_code_i,
  input  logic                        conversion_ok_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [dsma_pkg::SMP_W-1:0]  average_mv_o,
  output logic [dsma_pkg::HELD_W-1:0] samples_held_o
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int MVP_W  = CODE_BITS + dsma_pkg::SMP_W;
  localparam logic [dsma_pkg::DVS_W-1:0] CMAX = dsma_pkg::DVS_W'((64'd1 << CODE_BITS) - 1);

  dsma_pkg::dsma_state_e state_q, state_d;

  logic                       enable_q;
  logic [dsma_pkg::SMP_W-1:0] fs_q;
  logic [dsma_pkg::RES_W-1:0] top_q;
  logic [dsma_pkg::RES_W-1:0] bottom_q;

  logic [CODE_BITS-1:0]        code_q;
  logic [dsma_pkg::RAT_W-1:0]  ratio_q;
  logic [dsma_pkg::DVD_W-1:0]  prod_q, prod_d;
  logic [dsma_pkg::SMP_W-1:0]  mul_a;
  logic [dsma_pkg::RAT_W-1:0]  mul_b;
  logic [dsma_pkg::SMP_W-1:0]  mv_q;
  logic [dsma_pkg::SMP_W-1:0]  sample_q;
  logic [dsma_pkg::SMP_W-1:0]  sat_val;
  logic [dsma_pkg::SMP_W-1:0]  avg_q;
  logic [dsma_pkg::SMP_W-1:0]  res_avg_q;
  logic [dsma_pkg::HELD_W-1:0] res_held_q;
  logic [dsma_pkg::SMP_W-1:0]  out_avg_q;
  logic [dsma_pkg::HELD_W-1:0] out_held_q;
  logic                        out_valid_q;

  logic                        accept;
  logic                        out_free;
  logic                        push;
  logic [dsma_pkg::SUM_W-1:0]  win_sum;
  logic [FILL_W-1:0]           win_fill;

  dsma_pkg::div_req_t div_req;
  dsma_pkg::div_rsp_t div_rsp;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      fs_q     <= dsma_pkg::FS_RESET;
      top_q    <= dsma_pkg::TOP_RESET;
      bottom_q <= dsma_pkg::BOTTOM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dsma_pkg::CFG_ENABLE: enable_q <= cfg_data_i[0];
        dsma_pkg::CFG_FS:     fs_q     <= cfg_data_i[dsma_pkg::SMP_W-1:0];
        dsma_pkg::CFG_TOP:    top_q    <= cfg_data_i[dsma_pkg::RES_W-1:0];
        dsma_pkg::CFG_BOTTOM: bottom_q <= cfg_data_i[dsma_pkg::RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dsma_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (enable_q && conversion_ok_i) ? dsma_pkg::ST_MUL_MV : dsma_pkg::ST_RESP;
        end
      end
      dsma_pkg::ST_MUL_MV:  state_d = dsma_pkg::ST_LD_MV;
      dsma_pkg::ST_LD_MV:   state_d = dsma_pkg::ST_WAIT_MV;
      dsma_pkg::ST_WAIT_MV: begin
        if (div_rsp.done) begin
          state_d = dsma_pkg::ST_MUL_SC;
        end
      end
      dsma_pkg::ST_MUL_SC: begin
        state_d = (bottom_q == '0) ? dsma_pkg::ST_UPDATE : dsma_pkg::ST_LD_SC;
      end
      dsma_pkg::ST_LD_SC:   state_d = dsma_pkg::ST_WAIT_SC;
      dsma_pkg::ST_WAIT_SC: begin
        if (div_rsp.done) begin
          state_d = dsma_pkg::ST_UPDATE;
        end
      end
      dsma_pkg::ST_UPDATE:  state_d = dsma_pkg::ST_LD_AVG;
      dsma_pkg::ST_LD_AVG:  state_d = dsma_pkg::ST_WAIT_AVG;
      dsma_pkg::ST_WAIT_AVG: begin
        if (div_rsp.done) begin
          state_d = dsma_pkg::ST_RESP;
        end
      end
      dsma_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = dsma_pkg::ST_IDLE;
        end
      end
      default: state_d = dsma_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready_o       = 1'b0;
    push             = 1'b0;
    mul_a            = dsma_pkg::SMP_W'(code_q);
    mul_b            = dsma_pkg::RAT_W'(fs_q);
    div_req.start    = 1'b0;
    div_req.dividend = {prod_q[MVP_W-1:0], {(dsma_pkg::DVD_W - MVP_W){1'b0}}};
    div_req.divisor  = CMAX;
    div_req.steps    = dsma_pkg::CNT_W'(MVP_W);
    case (state_q)
      dsma_pkg::ST_IDLE:   in_ready_o = 1'b1;
      dsma_pkg::ST_MUL_SC: begin
        mul_a = mv_q;
        mul_b = ratio_q;
      end
      dsma_pkg::ST_LD_MV:  div_req.start = 1'b1;
      dsma_pkg::ST_LD_SC: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = bottom_q;
        div_req.steps    = dsma_pkg::CNT_W'(dsma_pkg::DVD_W);
      end
      dsma_pkg::ST_UPDATE: push = 1'b1;
      dsma_pkg::ST_LD_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = {win_sum, {(dsma_pkg::DVD_W - dsma_pkg::SUM_W){1'b0}}};
        div_req.divisor  = dsma_pkg::DVS_W'(win_fill);
        div_req.steps    = dsma_pkg::CNT_W'(dsma_pkg::SUM_W);
      end
      default: ;
    endcase
  end

  assign prod_d  = dsma_pkg::DVD_W'(mul_a) * dsma_pkg::DVD_W'(mul_b);
  assign sat_val = (|div_rsp.quotient[dsma_pkg::DVD_W-1:dsma_pkg::SMP_W])
                 ? dsma_pkg::SAT16 : div_rsp.quotient[dsma_pkg::SMP_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      code_q  <= adc_code_i;
      ratio_q <= dsma_pkg::RAT_W'(top_q) + dsma_pkg::RAT_W'(bottom_q);
    end
    if (state_q == dsma_pkg::ST_MUL_MV || state_q == dsma_pkg::ST_MUL_SC) begin
      prod_q <= prod_d;
    end
    if (state_q == dsma_pkg::ST_WAIT_MV && div_rsp.done) begin
      mv_q <= div_rsp.quotient[dsma_pkg::SMP_W-1:0];
    end
    if (state_q == dsma_pkg::ST_MUL_SC && bottom_q == '0) begin
      sample_q <= dsma_pkg::SAT16;
    end
    if (state_q == dsma_pkg::ST_WAIT_SC && div_rsp.done) begin
      sample_q <= sat_val;
    end
  end

  // Result and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q       <= '0;
      res_avg_q   <= '0;
      res_held_q  <= '0;
      out_avg_q   <= '0;
      out_held_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && !enable_q) begin
        res_avg_q  <= '0;
        res_held_q <= '0;
      end else if (accept && !conversion_ok_i) begin
        res_avg_q  <= avg_q;
        res_held_q <= dsma_pkg::HELD_W'(win_fill);
      end
      if (state_q == dsma_pkg::ST_WAIT_AVG && div_rsp.done) begin
        avg_q      <= div_rsp.quotient[dsma_pkg::SMP_W-1:0];
        res_avg_q  <= div_rsp.quotient[dsma_pkg::SMP_W-1:0];
        res_held_q <= dsma_pkg::HELD_W'(win_fill);
      end
      if (state_q == dsma_pkg::ST_RESP && out_free) begin
        out_avg_q   <= res_avg_q;
        out_held_q  <= res_held_q;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign average_mv_o   = out_avg_q;
  assign samples_held_o = out_held_q;

  dsma_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  dsma_window #(
    .DEPTH  (WINDOW_DEPTH),
    .SLOT_W (SLOT_W),
    .FILL_W (FILL_W)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .sample_i (sample_q),
    .sum_o    (win_sum),
    .fill_o   (win_fill)
  );

  `DSMA_ASSERT(a_fill_bound, win_fill <= FILL_W'(WINDOW_DEPTH))
  `DSMA_ASSERT(a_div_idle_start, div_req.start |-> !div_rsp.busy)
  `DSMA_ASSERT(a_empty_zero_avg, (out_valid_o && samples_held_o == '0) |-> average_mv_o == '0)

endmodule
